@@ rtl/core/depth_to_point_backprojection_defines.svh @@
// Assertion macros used by the checker file of the depth back-projection block.
// No dependencies; include with the bare file name.
`ifndef DEPTH_TO_POINT_BACKPROJECTION_DEFINES_SVH
`define DEPTH_TO_POINT_BACKPROJECTION_DEFINES_SVH

// same-cycle implication
`define DTPB_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DTPB_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/dtpb_pkg.sv @@
// Shared types and constants of the depth back-projection block.
// No dependencies; imported by the top level, dtpb_queue, dtpb_front and dtpb_back.
`timescale 1ns / 1ps

package dtpb_pkg;

  localparam int DEPTH_BITS_DEF = 16;
  localparam int COORD_BITS_DEF = 11;
  localparam int QUEUE_AW       = 2;

  localparam int IN_W  = 16;
  localparam int OUT_W = 35;
  localparam int Z_W   = 16;
  localparam int F_W   = 16;

  // saturation limits of the Q.8 coordinates
  localparam logic [35:0]      POS_LIM = 36'h3_FFFF_FFFF;
  localparam logic [35:0]      NEG_LIM = 36'h4_0000_0000;
  localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // register indexes
  localparam logic [2:0] REG_OUT_WIDTH  = 3'd0;
  localparam logic [2:0] REG_OUT_HEIGHT = 3'd1;
  localparam logic [2:0] REG_X_DEC      = 3'd2;
  localparam logic [2:0] REG_Y_DEC      = 3'd3;
  localparam logic [2:0] REG_NO_SAMPLE  = 3'd4;
  localparam logic [2:0] REG_SHADOW     = 3'd5;
  localparam logic [2:0] REG_INV_FOCAL  = 3'd6;

  typedef struct packed {
    logic [11:0] out_width;
    logic [11:0] out_height;
    logic [3:0]  x_dec;
    logic [3:0]  y_dec;
    logic [15:0] no_sample;
    logic [15:0] shadow;
    logic [15:0] inv_focal;
  } dtpb_cfg_t;

  localparam dtpb_cfg_t CFG_RESET = '{
    out_width:  12'd640,
    out_height: 12'd480,
    x_dec:      4'd1,
    y_dec:      4'd1,
    no_sample:  16'd0,
    shadow:     16'd0,
    inv_focal:  16'd125
  };

  typedef struct packed {
    logic end_of_frame;
    logic end_of_row;
    logic point_valid;
  } dtpb_flags_t;

  localparam int FLAGS_W = $bits(dtpb_flags_t);

endpackage

@@ rtl/core/depth_to_point_backprojection.sv @@
// Depth raster to 3-D point back-projection, top level with configuration registers.
// Depends on dtpb_pkg, dtpb_queue, dtpb_front and dtpb_back.
`timescale 1ns / 1ps

// Takes one depth sample per cycle in raster order while the queue has room and emits one
// point per kept pixel, so the sustained rate is one sample per clock while the output is
// not stalled. A point passes the queue and then the multiply, multiply, round and saturate
// stages of the back pipeline, and is held there while the output is stalled.
// A four-entry queue separates the raster counters from that pipeline, so a stalled
// output stops input only once it is full.
// Configuration writes are taken every cycle; write them only while no point is in flight.

module depth_to_point_backprojection
  import dtpb_pkg::*;
#(
  parameter int DEPTH_BITS = DEPTH_BITS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // depth_mm
  input  logic        s_axis_tuser,  // frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,  // x_q8[34:0], y_q8[69:35], z_mm[85:70], zero pad
  output logic [1:0]  m_axis_tuser,  // point_valid, end_of_frame
  output logic        m_axis_tlast   // end_of_row
);

  localparam int MW     = COORD_BITS + 1;
  localparam int ITEM_W = 2 + 2 * MW + DEPTH_BITS + FLAGS_W;

  dtpb_cfg_t             cfg;
  logic                  accept, emit, q_full, q_empty, q_pop;
  logic                  fx_neg, fy_neg, bx_neg, by_neg;
  logic [MW-1:0]         fx_mag, fy_mag, bx_mag, by_mag;
  logic [DEPTH_BITS-1:0] f_depth, b_depth;
  dtpb_flags_t           f_flags, b_flags, o_flags;
  logic [ITEM_W-1:0]     q_in, q_out;
  logic [OUT_W-1:0]      x_q8, y_q8;
  logic [Z_W-1:0]        z_mm;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_OUT_WIDTH:  cfg.out_width  <= cfg_data[11:0];
        REG_OUT_HEIGHT: cfg.out_height <= cfg_data[11:0];
        REG_X_DEC:      cfg.x_dec      <= cfg_data[3:0];
        REG_Y_DEC:      cfg.y_dec      <= cfg_data[3:0];
        REG_NO_SAMPLE:  cfg.no_sample  <= cfg_data;
        REG_SHADOW:     cfg.shadow     <= cfg_data;
        REG_INV_FOCAL:  cfg.inv_focal  <= cfg_data;
        default:        cfg            <= cfg;
      endcase
    end
  end

  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && !q_full;

  dtpb_front #(
    .DEPTH_BITS (DEPTH_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .accept      (accept),
    .depth_mm    (s_axis_tdata),
    .frame_start (s_axis_tuser),
    .emit        (emit),
    .x_neg       (fx_neg),
    .x_mag       (fx_mag),
    .y_neg       (fy_neg),
    .y_mag       (fy_mag),
    .depth       (f_depth),
    .flags       (f_flags)
  );

  assign q_in = {fx_neg, fx_mag, fy_neg, fy_mag, f_depth, f_flags};

  dtpb_queue #(
    .DATA_W (ITEM_W),
    .AW     (QUEUE_AW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && emit),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty),
    .full      (q_full)
  );

  assign {bx_neg, bx_mag, by_neg, by_mag, b_depth, b_flags} = q_out;

  dtpb_back #(
    .DEPTH_BITS (DEPTH_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .inv_focal (cfg.inv_focal),
    .in_avail  (!q_empty),
    .in_pop    (q_pop),
    .x_neg     (bx_neg),
    .x_mag     (bx_mag),
    .y_neg     (by_neg),
    .y_mag     (by_mag),
    .depth     (b_depth),
    .flags     (b_flags),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .x_q8      (x_q8),
    .y_q8      (y_q8),
    .z_mm      (z_mm),
    .out_flags (o_flags)
  );

  assign m_axis_tdata = {2'b00, z_mm, y_q8, x_q8};
  assign m_axis_tuser = {o_flags.end_of_frame, o_flags.point_valid};
  assign m_axis_tlast = o_flags.end_of_row;

endmodule

@@ rtl/core/dtpb_queue.sv @@
// Small register FIFO between the front and back parts.
// Depends on dtpb_pkg.
`timescale 1ns / 1ps

module dtpb_queue
  import dtpb_pkg::*;
#(
  parameter int DATA_W = 8,
  parameter int AW     = QUEUE_AW
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output logic              empty,
  output logic              full
);

  localparam int DEPTH = 1 << AW;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [AW-1:0]     wr_ptr;
  logic [AW-1:0]     rd_ptr;
  logic [AW:0]       count;

  assign empty    = (count == '0);
  assign full     = (count == (AW+1)'(DEPTH));
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (AW+1)'(1);
        2'b01:   count <= count - (AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/core/dtpb_front.sv @@
// Front part: raster counters, decimation, validity test and pixel offsets.
// Depends on dtpb_pkg.
`timescale 1ns / 1ps

module dtpb_front
  import dtpb_pkg::*;
#(
  parameter int DEPTH_BITS = DEPTH_BITS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dtpb_cfg_t             cfg,
  input  logic                  accept,
  input  logic [IN_W-1:0]       depth_mm,
  input  logic                  frame_start,
  output logic                  emit,
  output logic                  x_neg,
  output logic [COORD_BITS:0]   x_mag,
  output logic                  y_neg,
  output logic [COORD_BITS:0]   y_mag,
  output logic [DEPTH_BITS-1:0] depth,
  output dtpb_flags_t           flags
);

  localparam int SW = COORD_BITS + 1;
  localparam int NW = COORD_BITS + 2;

  logic [2:0]            col_phase, col_phase_next;
  logic [2:0]            row_phase, row_phase_next;
  logic [COORD_BITS-1:0] out_col, out_col_next;
  logic [COORD_BITS-1:0] out_row, out_row_next;

  logic [2:0]            cp, rp;
  logic [COORD_BITS-1:0] oc, orw;
  logic [12:0]           lim;
  logic [SW-1:0]         w, h;
  logic [3:0]            xd, yd;
  logic                  row_end, frame_end, col_wrap, row_wrap, row_last;
  logic [NW-1:0]         nx, ny;
  logic [DEPTH_BITS-1:0] d;
  logic                  valid;

  assign lim = 13'(1) << COORD_BITS;

  always_comb begin
    if (cfg.out_width == '0) begin
      w = SW'(1);
    end else if ({1'b0, cfg.out_width} > lim) begin
      w = SW'(lim);
    end else begin
      w = SW'(cfg.out_width);
    end
    if (cfg.out_height == '0) begin
      h = SW'(1);
    end else if ({1'b0, cfg.out_height} > lim) begin
      h = SW'(lim);
    end else begin
      h = SW'(cfg.out_height);
    end
    if (cfg.x_dec == '0) begin
      xd = 4'd1;
    end else if (cfg.x_dec > 4'd8) begin
      xd = 4'd8;
    end else begin
      xd = cfg.x_dec;
    end
    if (cfg.y_dec == '0) begin
      yd = 4'd1;
    end else if (cfg.y_dec > 4'd8) begin
      yd = 4'd8;
    end else begin
      yd = cfg.y_dec;
    end
  end

  // frame start clears the counters before the sample is used
  assign cp  = frame_start ? '0 : col_phase;
  assign rp  = frame_start ? '0 : row_phase;
  assign oc  = frame_start ? '0 : out_col;
  assign orw = frame_start ? '0 : out_row;

  assign row_end   = ({1'b0, oc} + SW'(1)) >= w;
  assign row_last  = ({1'b0, orw} + SW'(1)) >= h;
  assign frame_end = row_end && row_last;
  assign col_wrap  = ({1'b0, cp} + 4'd1) >= xd;
  assign row_wrap  = ({1'b0, rp} + 4'd1) >= yd;
  assign emit      = (cp == '0) && (rp == '0);

  always_comb begin
    col_phase_next = cp + 3'd1;
    row_phase_next = rp;
    out_col_next   = oc;
    out_row_next   = orw;
    if (col_wrap) begin
      col_phase_next = '0;
      if (row_end) begin
        out_col_next = '0;
        if (row_wrap) begin
          row_phase_next = '0;
          out_row_next   = row_last ? '0 : orw + COORD_BITS'(1);
        end else begin
          row_phase_next = rp + 3'd1;
        end
      end else begin
        out_col_next = oc + COORD_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_phase <= '0;
      row_phase <= '0;
      out_col   <= '0;
      out_row   <= '0;
    end else if (accept) begin
      col_phase <= col_phase_next;
      row_phase <= row_phase_next;
      out_col   <= out_col_next;
      out_row   <= out_row_next;
    end
  end

  // 2*pos + 1 - 2*floor(size/2)
  assign nx = $signed({1'b0, oc, 1'b1}) - $signed({1'b0, w[SW-1:1], 1'b0});
  assign ny = $signed({1'b0, orw, 1'b1}) - $signed({1'b0, h[SW-1:1], 1'b0});

  assign x_neg = nx[NW-1];
  assign y_neg = ny[NW-1];
  assign x_mag = x_neg ? SW'(-nx) : SW'(nx);
  assign y_mag = y_neg ? SW'(-ny) : SW'(ny);

  assign d     = depth_mm[DEPTH_BITS-1:0];
  assign valid = (d != '0) && (IN_W'(d) != cfg.no_sample) && (IN_W'(d) != cfg.shadow);
  // invalid points carry zero depth so every product is zero
  assign depth = valid ? d : '0;

  assign flags.point_valid  = valid;
  assign flags.end_of_row   = row_end;
  assign flags.end_of_frame = frame_end;

endmodule

@@ rtl/core/dtpb_back.sv @@
// Back part: four-stage multiply, round and saturate pipeline with output register.
// Depends on dtpb_pkg.
`timescale 1ns / 1ps

module dtpb_back
  import dtpb_pkg::*;
#(
  parameter int DEPTH_BITS = DEPTH_BITS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [F_W-1:0]        inv_focal,
  input  logic                  in_avail,
  output logic                  in_pop,
  input  logic                  x_neg,
  input  logic [COORD_BITS:0]   x_mag,
  input  logic                  y_neg,
  input  logic [COORD_BITS:0]   y_mag,
  input  logic [DEPTH_BITS-1:0] depth,
  input  dtpb_flags_t           flags,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_W-1:0]      x_q8,
  output logic [OUT_W-1:0]      y_q8,
  output logic [Z_W-1:0]        z_mm,
  output dtpb_flags_t           out_flags
);

  localparam int P1_W  = COORD_BITS + 1 + DEPTH_BITS;
  localparam int P2_W  = P1_W + F_W;
  localparam int Q_W   = P2_W - 8;
  localparam int CMP_W = (Q_W > 36) ? Q_W : 36;

  logic                  v1, v2, v3;
  logic                  en;
  logic [P1_W-1:0]       px1, py1;
  logic [P2_W-1:0]       mx2, my2;
  logic [P2_W:0]         sx, sy;
  logic [Q_W-1:0]        qx3, qy3;
  logic                  xn1, yn1, xn2, yn2, xn3, yn3;
  logic [DEPTH_BITS-1:0] z1, z2, z3;
  dtpb_flags_t           f1, f2, f3;

  function automatic logic [OUT_W-1:0] sat_q8(input logic neg, input logic [Q_W-1:0] q);
    logic [CMP_W-1:0] qe;
    logic [CMP_W-1:0] qn;
    logic [OUT_W-1:0] r;
    qe = CMP_W'(q);
    qn = CMP_W'(0) - qe;
    if (neg) begin
      r = (qe > CMP_W'(NEG_LIM)) ? OUT_MIN : qn[OUT_W-1:0];
    end else begin
      r = (qe > CMP_W'(POS_LIM)) ? OUT_MAX : qe[OUT_W-1:0];
    end
    return r;
  endfunction

  assign en     = !out_valid || out_ready;
  assign in_pop = en && in_avail;

  // negative offsets round toward minus infinity
  assign sx = {1'b0, mx2} + (P2_W+1)'(xn2 ? 511 : 0);
  assign sy = {1'b0, my2} + (P2_W+1)'(yn2 ? 511 : 0);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_pop;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px1       <= P1_W'(x_mag * depth);
      py1       <= P1_W'(y_mag * depth);
      xn1       <= x_neg;
      yn1       <= y_neg;
      z1        <= depth;
      f1        <= flags;
      mx2       <= P2_W'(px1 * inv_focal);
      my2       <= P2_W'(py1 * inv_focal);
      xn2       <= xn1;
      yn2       <= yn1;
      z2        <= z1;
      f2        <= f1;
      qx3       <= sx[P2_W:9];
      qy3       <= sy[P2_W:9];
      xn3       <= xn2;
      yn3       <= yn2;
      z3        <= z2;
      f3        <= f2;
      x_q8      <= sat_q8(xn3, qx3);
      y_q8      <= sat_q8(yn3, qy3);
      z_mm      <= Z_W'(z3);
      out_flags <= f3;
    end
  end

endmodule

@@ rtl/core/dtpb_checker.sv @@
// Port-level checks of the depth back-projection block, bound to the top level.
// Depends on depth_to_point_backprojection_defines.svh and the top level.
`timescale 1ns / 1ps
`include "depth_to_point_backprojection_defines.svh"

module dtpb_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [87:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  `DTPB_ASSERT_NXT(a_reset_idle, clk, 1'b0, rst, !m_axis_tvalid, "output valid right after reset")

  `DTPB_ASSERT_IMP(a_invalid_zero, clk, rst, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == '0, "invalid point with nonzero payload")

  `DTPB_ASSERT_IMP(a_valid_depth, clk, rst, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[85:70] != '0, "valid point with zero depth")

  `DTPB_ASSERT_IMP(a_frame_row, clk, rst, m_axis_tvalid && m_axis_tuser[1], m_axis_tlast, "frame end without row end")

  `DTPB_ASSERT_NXT(a_stall_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled request changed")

endmodule

bind depth_to_point_backprojection dtpb_checker u_dtpb_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

@@ test/depth_to_point_backprojection_tb.sv @@
// Self-checking testbench for depth_to_point_backprojection: streams depth rasters under
// varied register settings and compares every point with an in-bench back-projection model.
// Depends on dtpb_pkg and the RTL of the block.
`timescale 1ns / 1ps

module depth_to_point_backprojection_tb;
  import dtpb_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 10;
  localparam int MAX_REPORTS    = 60;

  typedef struct packed {
    logic [34:0] x;
    logic [34:0] y;
    logic [15:0] z;
    logic        valid;
    logic        eor;
    logic        eof;
  } point_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_OUT_WIDTH;
  logic [15:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // depth_mm
  logic        s_axis_tuser = 1'b0; // frame_start
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;        // x_q8[34:0], y_q8[69:35], z_mm[85:70], zero pad
  logic [1:0]  m_axis_tuser;        // point_valid, end_of_frame
  logic        m_axis_tlast;        // end_of_row

  depth_to_point_backprojection u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // raster model state
  dtpb_cfg_t   regs = CFG_RESET;
  logic [2:0]  col_ph = '0;
  logic [2:0]  row_ph = '0;
  logic [10:0] col_pos = '0;
  logic [10:0] row_pos = '0;
  point_t      pending_points[$];

  int  fault_count = 0;
  int  points_checked = 0;
  int  samples_sent = 0;
  int  reg_writes = 0;
  int  settings_used = 0;
  int  idle_cycles = 0;
  int  stall_hold = 0;
  bit  gap_on = 1'b0;
  bit  stall_on = 1'b0;

  function automatic int unsigned clamp_size(logic [11:0] s);
    if (s == 0) return 1;
    return (s > 12'd2048) ? 2048 : s;
  endfunction

  function automatic int unsigned clamp_dec(logic [3:0] s);
    if (s == 0) return 1;
    return (s > 4'd8) ? 8 : s;
  endfunction

  // floor(n * d * f / 512), saturated to 35 bits
  function automatic logic [34:0] backproject(int unsigned pos, int unsigned size,
                                              logic [15:0] d, logic [15:0] f);
    longint          n;
    longint unsigned mag, q, dd, ff;
    longint          r;
    dd = d;
    ff = f;
    n = 2 * longint'(pos) - 2 * longint'(size / 2) + 1;
    mag = longint'(n < 0 ? -n : n) * dd * ff;
    if (n >= 0) begin
      q = mag >> 9;
      if (q > 64'h3_FFFF_FFFF) return OUT_MAX;
      r = q;
    end else begin
      q = (mag + 511) >> 9;
      if (q > 64'h4_0000_0000) return OUT_MIN;
      r = -longint'(q);
    end
    return r[34:0];
  endfunction

  function automatic void advance_raster(logic [15:0] d, logic fs);
    int unsigned w, h, xd, yd;
    bit          row_end, frame_end, ok;
    point_t      p;
    w = clamp_size(regs.out_width);
    h = clamp_size(regs.out_height);
    xd = clamp_dec(regs.x_dec);
    yd = clamp_dec(regs.y_dec);
    if (fs) begin
      col_ph = '0;
      row_ph = '0;
      col_pos = '0;
      row_pos = '0;
    end
    row_end = (int'(col_pos) + 1) >= w;
    frame_end = row_end && ((int'(row_pos) + 1) >= h);
    if (col_ph == 0 && row_ph == 0) begin
      ok = (d != 0) && (d != regs.no_sample) && (d != regs.shadow);
      p.x = ok ? backproject(col_pos, w, d, regs.inv_focal) : '0;
      p.y = ok ? backproject(row_pos, h, d, regs.inv_focal) : '0;
      p.z = ok ? d : '0;
      p.valid = ok;
      p.eor = row_end;
      p.eof = frame_end;
      pending_points.push_back(p);
    end
    if ((int'(col_ph) + 1) >= xd) begin
      col_ph = '0;
      if (row_end) begin
        col_pos = '0;
        if ((int'(row_ph) + 1) >= yd) begin
          row_ph = '0;
          if ((int'(row_pos) + 1) >= h) row_pos = '0;
          else row_pos = row_pos + 1'b1;
        end else begin
          row_ph = row_ph + 1'b1;
        end
      end else begin
        col_pos = col_pos + 1'b1;
      end
    end else begin
      col_ph = col_ph + 1'b1;
    end
  endfunction

  function automatic int pick_gap(bit enable);
    int r;
    if (!enable) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver back-pressure
  always @(posedge clk) begin
    logic rdy_next;
    if (stall_hold > 0) begin
      stall_hold = stall_hold - 1;
      rdy_next = 1'b0;
    end else if (stall_on && $urandom_range(0, 99) < 30) begin
      stall_hold = pick_gap(1'b1);
      rdy_next = 1'b0;
    end else begin
      rdy_next = 1'b1;
    end
    m_axis_tready <= rdy_next;
  end

  task automatic check_field(string name, longint want_v, longint got_v);
    if (want_v != got_v) begin
      fault_count++;
      if (fault_count <= MAX_REPORTS)
        $display("%0t: %s expected %0d actual %0d", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    point_t want, got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.x = m_axis_tdata[34:0];
      got.y = m_axis_tdata[69:35];
      got.z = m_axis_tdata[85:70];
      got.valid = m_axis_tuser[0];
      got.eof = m_axis_tuser[1];
      got.eor = m_axis_tlast;
      if (pending_points.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS)
          $display("%0t: unexpected point expected none actual x=%0d y=%0d z=%0d",
                   $time, $signed(got.x), $signed(got.y), got.z);
      end else begin
        want = pending_points.pop_front();
        points_checked++;
        check_field("x_q8", $signed(want.x), $signed(got.x));
        check_field("y_q8", $signed(want.y), $signed(got.y));
        check_field("z_mm", want.z, got.z);
        check_field("point_valid", want.valid, got.valid);
        check_field("end_of_row", want.eor, got.eor);
        check_field("end_of_frame", want.eof, got.eof);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress, %0d points outstanding", $time, pending_points.size());
        $display("depth_to_point_backprojection: mismatch");
        $finish;
      end
    end
  end

  task automatic push_depth(input logic [15:0] d, input logic fs);
    int gap;
    gap = pick_gap(gap_on);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    s_axis_tuser <= fs;
    do @(posedge clk); while (!s_axis_tready);
    advance_raster(d, fs);
    samples_sent++;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_OUT_WIDTH:  regs.out_width = val[11:0];
      REG_OUT_HEIGHT: regs.out_height = val[11:0];
      REG_X_DEC:      regs.x_dec = val[3:0];
      REG_Y_DEC:      regs.y_dec = val[3:0];
      REG_NO_SAMPLE:  regs.no_sample = val;
      REG_SHADOW:     regs.shadow = val;
      REG_INV_FOCAL:  regs.inv_focal = val;
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic set_geometry(input logic [15:0] w, input logic [15:0] h,
                              input logic [15:0] xd, input logic [15:0] yd);
    write_reg(REG_OUT_WIDTH, w);
    write_reg(REG_OUT_HEIGHT, h);
    write_reg(REG_X_DEC, xd);
    write_reg(REG_Y_DEC, yd);
    settings_used++;
  endtask

  task automatic test_reset_config();
    settings_used++;
    push_depth(16'd1000, 1'b1);
    push_depth(16'd0, 1'b0);
    push_depth(16'hFFFF, 1'b0);
    push_depth(16'd1, 1'b0);
    settle();
  endtask

  task automatic test_invalid_codes();
    set_geometry(16'd2, 16'd2, 16'd1, 16'd1);
    write_reg(REG_NO_SAMPLE, 16'h1234);
    write_reg(REG_SHADOW, 16'hFFFF);
    write_reg(REG_INV_FOCAL, 16'hFFFF);
    push_depth(16'h1234, 1'b1);
    push_depth(16'hFFFF, 1'b0);
    push_depth(16'h1235, 1'b0);
    push_depth(16'h0000, 1'b0);
    settle();
  endtask

  task automatic test_decimation();
    set_geometry(16'd2, 16'd1, 16'd2, 16'd2);
    write_reg(REG_INV_FOCAL, 16'd1);
    for (int i = 0; i < 8; i++) push_depth(16'($urandom_range(1, 65535)), i == 0);
    settle();
    // zero and oversized decimation, minimum frame, wrap into next frame
    set_geometry(16'd1, 16'd1, 16'd0, 16'd9);
    write_reg(REG_INV_FOCAL, 16'd40000);
    for (int i = 0; i < 9; i++) push_depth(16'($urandom_range(1, 65535)), i == 0);
    settle();
  endtask

  task automatic test_size_change();
    set_geometry(16'd4, 16'd3, 16'd1, 16'd1);
    push_depth(16'd500, 1'b1);
    push_depth(16'd600, 1'b0);
    push_depth(16'd700, 1'b0);
    settle();
    // column 3 now lies past the new width
    set_geometry(16'd2, 16'd3, 16'd1, 16'd1);
    push_depth(16'd800, 1'b0);
    settle();
  endtask

  task automatic test_wide_row();
    set_geometry(16'hFFFF, 16'hFFFF, 16'd1, 16'd1);
    write_reg(REG_NO_SAMPLE, 16'd0);
    write_reg(REG_SHADOW, 16'd0);
    write_reg(REG_INV_FOCAL, 16'hFFFF);
    gap_on = 1'b1;
    stall_on = 1'b1;
    // clamped width; runs past the row center
    for (int i = 0; i < 1060; i++)
      push_depth(($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'hFFFF, i == 0);
    settle();
  endtask

  function automatic logic [15:0] random_size(int unsigned small_max);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 16'($urandom_range(1, small_max));
    if (r < 80) return 16'd0;
    if (r < 90) return 16'($urandom_range(small_max + 1, 40));
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] random_dec();
    if ($urandom_range(0, 99) < 60) return 16'($urandom_range(1, 3));
    return 16'($urandom_range(0, 15));
  endfunction

  function automatic logic [15:0] random_depth();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'd0;
    if (r < 20) return regs.no_sample;
    if (r < 30) return regs.shadow;
    if (r < 35) return 16'hFFFF;
    if (r < 40) return 16'd1;
    return 16'($urandom);
  endfunction

  task automatic test_random_frames();
    int          budget, frame_len, r;
    logic [15:0] f;
    for (int phase = 0; phase < 14; phase++) begin
      set_geometry(random_size(6), random_size(5), random_dec(), random_dec());
      write_reg(REG_NO_SAMPLE, 16'($urandom));
      write_reg(REG_SHADOW, 16'($urandom));
      r = $urandom_range(0, 99);
      f = (r < 20) ? 16'hFFFF : (r < 30) ? 16'd1 : 16'($urandom_range(1, 65535));
      write_reg(REG_INV_FOCAL, f);
      gap_on = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      budget = $urandom_range(10, 30);
      while (budget > 0) begin
        frame_len = clamp_size(regs.out_width) * clamp_size(regs.out_height) *
                    clamp_dec(regs.x_dec) * clamp_dec(regs.y_dec);
        // most frames open with frame_start, some run on from the wrap
        r = $urandom_range(0, 99);
        for (int i = 0; i < frame_len && budget > 0; i++) begin
          push_depth(random_depth(),
                     (i == 0 && r < 85) || ($urandom_range(0, 99) < 3));
          budget--;
        end
      end
      settle();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_config();
    gap_on = 1'b1;
    stall_on = 1'b1;
    test_invalid_codes();
    gap_on = 1'b0;
    stall_on = 1'b0;
    test_decimation();
    gap_on = 1'b1;
    test_size_change();
    test_wide_row();
    test_random_frames();
    settle();
    $display("Streamed %0d depth samples over %0d register settings (%0d writes);",
             samples_sent, settings_used, reg_writes);
    $display("checked %0d points, %0d faults.", points_checked, fault_count);
    if (fault_count == 0 && pending_points.size() == 0) begin
      $display("depth_to_point_backprojection: match");
    end else begin
      $display("depth_to_point_backprojection: mismatch");
    end
    $finish;
  end

endmodule
